// ===== rtl/radix_digit_emitter_macros.svh =====
// ----------------------------------------------------------------------------
// Radix digit emitter assertion macros
// Shared property wrappers for the digit emitter RTL.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_MACROS_SVH
`define RADIX_DIGIT_EMITTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RDE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter package
// Shared constants, types and the digit-to-ASCII function.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int RADIX_W       = 5;
   localparam int DIGIT_W       = 4;
   localparam int CHAR_W        = 7;
   localparam int DIV_STEP_BITS = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;
   localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd55;
   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] rem;
   } rde_div_status_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < DECIMAL_LIMIT) begin
         return CHAR_ZERO + d_ext;
      end
      return LETTER_OFFSET + d_ext;
   endfunction

endpackage

// ===== rtl/rde_divider.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter divider
// Restoring divider by a small radix, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module rde_divider #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [VALUE_BITS-1:0]               dividend,
   input  logic [rde_pkg::RADIX_W-1:0]         divisor,
   output logic [VALUE_BITS-1:0]               quotient,
   output rde_pkg::rde_div_status_type         status
);

   localparam int STEPS = (VALUE_BITS + rde_pkg::DIV_STEP_BITS - 1) / rde_pkg::DIV_STEP_BITS;
   localparam int DIV_W = STEPS * rde_pkg::DIV_STEP_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DIV_W-1:0]                     work_ff;
   logic [rde_pkg::DIGIT_W-1:0]          rem_ff;
   logic [rde_pkg::DIGIT_W-1:0]          rem_in;
   logic [CNT_W-1:0]                     cnt_ff;
   logic                                 busy_ff;
   logic                                 done_ff;
   logic [rde_pkg::DIV_STEP_BITS-1:0]    qbits_in;

   // One slice of long division: shift in a dividend bit, subtract if it fits.
   always_comb begin
      logic [rde_pkg::RADIX_W-1:0] trial;
      rem_in   = rem_ff;
      qbits_in = '0;
      for (int i = 0; i < rde_pkg::DIV_STEP_BITS; i++) begin
         trial = {rem_in, work_ff[DIV_W-1-i]};
         if (trial >= divisor) begin
            rem_in = rde_pkg::DIGIT_W'(trial - divisor);
            qbits_in[rde_pkg::DIV_STEP_BITS-1-i] = 1'b1;
         end else begin
            rem_in = trial[rde_pkg::DIGIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         work_ff <= DIV_W'(dividend);
         rem_ff  <= '0;
         cnt_ff  <= CNT_W'(STEPS - 1);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         work_ff <= DIV_W'({work_ff, qbits_in});
         rem_ff  <= rem_in;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign quotient    = work_ff[VALUE_BITS-1:0];
   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

// ===== rtl/radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter
// Converts an unsigned value to ASCII digits in a programmable base 2..16.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one value per transaction (low VALUE_BITS bits are used).
//   rsp_* returns one ASCII digit per transaction, most significant first,
//   with rsp_tlast on the least significant digit. A zero value, or a radix
//   outside 2..16, yields no transaction at all.
//   csr_* writes the 5-bit radix; write it only while the block is idle.
// Sequence:
//   Digits are peeled off least significant first by one shared divider that
//   retires eight quotient bits per cycle, each division starting straight
//   off the previous quotient. Digits are parked in a small stack memory and
//   read back MSD first, each through the registered memory read (ST_FETCH,
//   then ST_SEND). req_tready stays low until the last digit of an item has
//   been registered, so the block takes one value at a time.
// Reset and stall:
//   Reset drops every transaction in flight and restores radix 10. A stalled
//   receiver holds the result register; the sequencer waits until it drains.
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_macros.svh"

module radix_digit_emitter #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata[31:0] = value
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: tdata[6:0] = digit_char, tdata[7] = 0; tlast = is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // radix register write: data[4:0] = radix
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   localparam int IDX_W = $clog2(VALUE_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FETCH,
      ST_SEND
   } state_type;

   state_type                          state_ff;
   logic [rde_pkg::RADIX_W-1:0]        radix_ff;
   logic [IDX_W-1:0]                   wr_ptr_ff;
   logic [IDX_W-1:0]                   rd_ptr_ff;
   logic [rde_pkg::DIGIT_W-1:0]        digit_mem [VALUE_BITS];
   logic [rde_pkg::DIGIT_W-1:0]        rd_data_ff;
   logic                               rsp_tvalid_ff;
   logic [rde_pkg::CHAR_W-1:0]         rsp_char_ff;
   logic                               rsp_tlast_ff;

   logic [VALUE_BITS-1:0]              value_in;
   logic                               req_accept;
   logic                               radix_ok;
   logic                               item_go;
   logic                               div_start;
   logic [VALUE_BITS-1:0]              div_dividend;
   logic [VALUE_BITS-1:0]              div_quotient;
   rde_pkg::rde_div_status_type        div_status;
   logic                               digit_done;
   logic                               quot_zero;
   logic                               slot_free;

   // Keep only the low VALUE_BITS bits of the request.
   assign value_in   = VALUE_BITS'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign radix_ok   = (radix_ff >= rde_pkg::RADIX_MIN) && (radix_ff <= rde_pkg::RADIX_MAX);
   assign item_go    = req_accept && radix_ok && (value_in != '0);

   assign digit_done = (state_ff == ST_DIV) && div_status.done;
   assign quot_zero  = (div_quotient == '0);

   // Chain the next division straight off the previous quotient.
   assign div_start    = item_go || (digit_done && !quot_zero);
   assign div_dividend = (state_ff == ST_IDLE) ? value_in : div_quotient;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   rde_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Radix register; the write channel never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rde_pkg::RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_data;
      end
   end

   // Digit stack: push remainders LSD first, pop MSD first.
   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_mem[wr_ptr_ff] <= div_status.rem;
      end
      rd_data_ff <= digit_mem[rd_ptr_ff];
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // Drop valid once taken; in ST_SEND the next digit decides it.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_SEND)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               // Zero value or bad radix: drop the transaction, stay idle.
               if (item_go) begin
                  wr_ptr_ff <= '0;
                  state_ff  <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (digit_done) begin
                  if (quot_zero) begin
                     rd_ptr_ff <= wr_ptr_ff;
                     state_ff  <= ST_FETCH;
                  end else begin
                     wr_ptr_ff <= wr_ptr_ff + 1'b1;
                  end
               end
            end
            ST_FETCH: begin
               // Memory read of rd_ptr_ff lands in rd_data_ff at this edge.
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (slot_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_char_ff   <= rde_pkg::digit_to_char(rd_data_ff);
                  rsp_tlast_ff  <= (rd_ptr_ff == '0);
                  if (rd_ptr_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     rd_ptr_ff <= rd_ptr_ff - 1'b1;
                     state_ff  <= ST_FETCH;
                  end
               end else begin
                  rsp_tvalid_ff <= rsp_tvalid_ff;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_tlast_ff;

   // A request that yields no digits must leave the block idle.
   `RDE_ASSERT_NEXT(a_drop_stays_idle, clock, reset, req_accept && !item_go, state_ff == ST_IDLE, "dropped request left the block busy")

   // The divider only finishes while the sequencer waits for it.
   `RDE_ASSERT_IMPL(a_done_in_div, clock, reset, div_status.done, state_ff == ST_DIV, "divider finished outside the divide phase")

   // The bottom of the stack is the final digit and ends the run.
   `RDE_ASSERT_NEXT(a_last_ends_run, clock, reset, (state_ff == ST_SEND) && slot_free && (rd_ptr_ff == '0), rsp_tvalid && rsp_tlast && (state_ff == ST_IDLE), "final digit did not close the run")

   // Every emitted character is a legal digit, 0-9 or A-F.
   `RDE_ASSERT_IMPL(a_char_range, clock, reset, rsp_tvalid, ((rsp_tdata >= 8'd48) && (rsp_tdata <= 8'd57)) || ((rsp_tdata >= 8'd65) && (rsp_tdata <= 8'd70)), "emitted character is not a digit")

endmodule

// ===== test/radix_digit_emitter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix digit emitter testbench
// Streams values into the emitter across a series of radix settings (valid
// bases, their edges and out-of-range bases) and checks every ASCII digit
// and its last flag against a digit predictor kept in a scoreboard. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------

class digit_scoreboard;

   typedef struct packed {
      logic [rde_pkg::CHAR_W-1:0] digit_char;
      logic                       is_last;
   } digit_result_type;

   digit_result_type            expected_digits[$];
   logic [rde_pkg::RADIX_W-1:0] radix;
   int                          error_count;

   function new();
      radix       = rde_pkg::RADIX_RESET;
      error_count = 0;
   endfunction

   task report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Expand one accepted value into its digits, most significant first.
   task note_value(input logic [31:0] value);
      logic [31:0]                 rest;
      logic [rde_pkg::DIGIT_W-1:0] digit;
      logic [rde_pkg::DIGIT_W-1:0] digits[$];
      digit_result_type            item;
      if (value == 0 || radix < rde_pkg::RADIX_MIN || radix > rde_pkg::RADIX_MAX) return;
      rest = value;
      while (rest != 0) begin
         digit = rde_pkg::DIGIT_W'(rest % {27'd0, radix});
         digits.push_front(digit);
         rest = rest / {27'd0, radix};
      end
      foreach (digits[i]) begin
         if (digits[i] < 4'd10) begin
            item.digit_char = rde_pkg::CHAR_ZERO + rde_pkg::CHAR_W'(digits[i]);
         end else begin
            item.digit_char = rde_pkg::LETTER_OFFSET + rde_pkg::CHAR_W'(digits[i]);
         end
         item.is_last = (i == digits.size() - 1);
         expected_digits.push_back(item);
      end
   endtask

   task check_digit(input logic [7:0] tdata, input logic tlast);
      digit_result_type want;
      if (expected_digits.size() == 0) begin
         report_mismatch($sformatf("unexpected digit 0x%02h last=%0b", tdata, tlast));
         return;
      end
      want = expected_digits.pop_front();
      if (tdata[rde_pkg::CHAR_W-1:0] !== want.digit_char)
         report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                   tdata[rde_pkg::CHAR_W-1:0], want.digit_char));
      if (tdata[7] !== 1'b0)
         report_mismatch("tdata pad bit set");
      if (tlast !== want.is_last)
         report_mismatch($sformatf("is_last %0b, expected %0b", tlast, want.is_last));
   endtask

endclass

module radix_digit_emitter_test;

   // Settle time, long enough for the longest item of 32 digits.
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 2_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_data;

   int unsigned     cycle_count = 0;
   digit_scoreboard digits_sb   = new();

   radix_digit_emitter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Check every digit transaction at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) digits_sb.check_digit(rsp_tdata, rsp_tlast);
   end

   // Watchdog: a correct run never gets near this.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("DONE: errors detected");
      $finish;
   end

   // Sender gap: mostly none, some short, a few long; dense stretches skip it.
   function automatic int pick_gap(input bit dense);
      int r;
      r = $urandom_range(0, 99);
      if (dense || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // Random value: full range mostly, with zeros, small values and values
   // sitting on a power of the radix (where the digit count steps up).
   function automatic logic [31:0] pick_value();
      logic [63:0] power;
      int          k;
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom_range(1, 20);
         2: return $urandom_range(1, 1000);
         3: begin
            if (digits_sb.radix < rde_pkg::RADIX_MIN || digits_sb.radix > rde_pkg::RADIX_MAX)
               return $urandom;
            power = 64'd1;
            k     = $urandom_range(1, 31);
            repeat (k) begin
               if (power <= 64'hFFFF_FFFF / digits_sb.radix) power = power * digits_sb.radix;
            end
            return 32'(power - $urandom_range(0, 1));
         end
         4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Called just after a falling edge; returns just after a falling edge
   // with req_tvalid still high so a following value can go back to back.
   task automatic send_value(input logic [31:0] value, input bit dense);
      int gap;
      gap = pick_gap(dense);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      digits_sb.note_value(value);
      @(negedge clock);
   endtask

   // Hold off the sender until every expected digit has come back.
   task automatic drain_digits();
      req_tvalid = 1'b0;
      while (digits_sb.expected_digits.size() != 0) @(negedge clock);
   endtask

   // Write the radix only once the block is idle; a value that made no digit
   // can still be in flight, so let the settle time pass as well.
   task automatic write_radix(input logic [4:0] radix);
      drain_digits();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = radix;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      digits_sb.radix = radix;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver: ready runs of random length, short stalls, now and then a long one.
   task automatic drive_response_ready();
      int  r;
      int  run_len;
      bit  ready_level;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            ready_level = 1'b1;
            run_len     = $urandom_range(1, 40);
         end else if (r < 95) begin
            ready_level = 1'b0;
            run_len     = $urandom_range(1, 3);
         end else begin
            ready_level = 1'b0;
            run_len     = $urandom_range(20, 60);
         end
         rsp_tready = ready_level;
         repeat (run_len) @(negedge clock);
      end
   endtask

   // Random phase: mostly valid bases, a couple out of range.
   task automatic run_phase(input logic [4:0] radix, input int count, input bit dense);
      write_radix(radix);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 || $urandom_range(0, 15) == 0) drain_digits();
         send_value(pick_value(), dense);
      end
   endtask

   initial begin
      fork
         begin
            @(negedge clock);
            wait (!reset);
            drive_response_ready();
         end
      join_none
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: decimal out of reset, including zero, one and full range.
      send_value(32'd0, 1'b0);
      send_value(32'd1, 1'b1);
      send_value(32'd9, 1'b1);
      send_value(32'd10, 1'b1);
      send_value(32'hFFFF_FFFF, 1'b0);
      send_value(32'h8000_0000, 1'b0);
      send_value(32'd4_000_000_000, 1'b1);

      // Hex covers the letter digits, binary the longest runs.
      write_radix(rde_pkg::RADIX_MAX);
      send_value(32'd15, 1'b1);
      send_value(32'hFEDC_BA98, 1'b1);
      send_value(32'hABCD_EF01, 1'b0);
      write_radix(rde_pkg::RADIX_MIN);
      send_value(32'd1, 1'b1);
      send_value(32'hFFFF_FFFF, 1'b1);
      send_value(32'h5555_5555, 1'b0);

      // Out-of-range bases: nothing comes back, whatever the value.
      write_radix(5'd0);
      send_value(32'd5, 1'b1);
      write_radix(5'd1);
      send_value(32'd5, 1'b0);
      write_radix(5'd17);
      send_value(32'h0000_FFFF, 1'b1);
      write_radix(5'd31);
      send_value(32'd123, 1'b0);

      // Random phases.
      run_phase(rde_pkg::RADIX_MAX, 17, 1'b0);
      run_phase(rde_pkg::RADIX_MIN, 17, 1'b1);
      run_phase(5'd8, 17, 1'b0);
      run_phase(5'd3, 17, 1'b1);
      run_phase(5'($urandom_range(2, 16)), 17, 1'b0);
      run_phase(5'd0, 4, 1'b0);
      run_phase(5'($urandom_range(2, 16)), 17, 1'b1);
      run_phase(5'd13, 17, 1'b0);
      run_phase(5'($urandom_range(17, 31)), 4, 1'b1);
      run_phase(rde_pkg::RADIX_RESET, 17, 1'b0);

      drain_digits();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (digits_sb.error_count == 0 && digits_sb.expected_digits.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
